/* rtl/ufsf_pkg.sv */
// ----------------------------------------------------------------------------
// ufsf_pkg
// Shared types and codes for the spanning forest block: request and result
// payloads, the microcode control word, datapath status flags and the codes
// that the control word carries.
// ----------------------------------------------------------------------------
package ufsf_pkg;

  // fixed field widths
  localparam int NODE_W = 11;
  localparam int ENUM_W = 16;
  localparam int STEP_W = 4;

  // request payload
  typedef struct packed {
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic              last_edge;
  } ufsf_in_t;

  // result payload
  typedef struct packed {
    logic              joined;
    logic [ENUM_W-1:0] edge_number;
    logic [NODE_W-1:0] components;
    logic              connected;
    logic              final_res;
    logic              bad_node;
  } ufsf_out_t;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK  = 4'd1;
  localparam logic [STEP_W-1:0] S_WALK   = 4'd2;
  localparam logic [STEP_W-1:0] S_REWIND = 4'd3;
  localparam logic [STEP_W-1:0] S_CTEST  = 4'd4;
  localparam logic [STEP_W-1:0] S_CPATH  = 4'd5;
  localparam logic [STEP_W-1:0] S_PHASE  = 4'd6;
  localparam logic [STEP_W-1:0] S_LOAD_B = 4'd7;
  localparam logic [STEP_W-1:0] S_READ_B = 4'd8;
  localparam logic [STEP_W-1:0] S_LINK   = 4'd9;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd10;

  // branch conditions
  localparam logic [3:0] C_NEVER       = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_NO_REQ      = 4'd2;
  localparam logic [3:0] C_BAD         = 4'd3;
  localparam logic [3:0] C_RD_NE_CUR   = 4'd4;
  localparam logic [3:0] C_CUR_EQ_ROOT = 4'd5;
  localparam logic [3:0] C_RD_NE_ROOT  = 4'd6;
  localparam logic [3:0] C_PHASE_B     = 4'd7;
  localparam logic [3:0] C_OUT_BUSY    = 4'd8;

  // walk pointer operations
  localparam logic [1:0] CUR_HOLD   = 2'd0;
  localparam logic [1:0] CUR_START  = 2'd1;
  localparam logic [1:0] CUR_FOLLOW = 2'd2;
  localparam logic [1:0] CUR_SECOND = 2'd3;

  // parent memory read operations
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_DATA = 2'd2;

  // one microcode word
  typedef struct packed {
    logic [3:0]        cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
    logic              take;
    logic [1:0]        cur_op;
    logic [1:0]        rd_op;
    logic              wr_path;
    logic              root_ld;
    logic              link;
    logic              out_ld;
  } ufsf_ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic clr_busy;
    logic bad;
    logic rd_ne_cur;
    logic cur_eq_root;
    logic rd_ne_root;
    logic phase_b;
  } ufsf_flags_t;

endpackage

/* rtl/union_find_spanning_forest.sv */
// ----------------------------------------------------------------------------
// union_find_spanning_forest
// Spanning forest builder: one edge per request, disjoint-set parent memory
// with path compression, one result per edge.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one edge (two node labels and a last
//   flag). out_valid/out_stall/out_data return one result per edge: joined
//   flag, running edge number, component count, connected flag, copy of the
//   last flag and the bad label flag. cfg_wr_en/cfg_wr_data set node_count;
//   write it only while no edge is in flight.
//   Sequencing: a microcode sequencer runs both root walks and the compression
//   passes through a parent memory with a registered read port. Each parent
//   hop of a walk and each re-pointed node is a microcode step of its own.
//   An edge with a bad label goes from the check step straight to the
//   output step. The next request is taken in the idle step, which follows
//   the step that loads the result, so the block holds one edge at a time.
//   Reset: a clearing sweep over all MAX_NODES entries makes every node its
//   own parent; in_stall stays high meanwhile. Counters clear, node_count = 1024.
//   A stalled result holds in the output register; the block finishes the
//   next edge and then waits in its output step until the register frees.
// ----------------------------------------------------------------------------
module union_find_spanning_forest
  import ufsf_pkg::*;
#(
  parameter int MAX_NODES       = 1024,
  parameter int EDGE_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ufsf_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ufsf_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = ((NW + 1) > 12) ? (NW + 1) : 12;
  localparam logic [CW-1:0] MAXN = CW'(MAX_NODES);

  logic [NODE_W-1:0] nc_r;
  logic [CW-1:0]     node_lim;
  ufsf_ctrl_t        ctrl;
  ufsf_flags_t       flags;
  ufsf_out_t         res;
  logic              out_valid_r;
  ufsf_out_t         out_data_r;
  logic              out_busy;

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= 11'd1024;
    end else if (cfg_wr_en) begin
      nc_r <= cfg_wr_data;
    end
  end

  // effective node count, clamped to 1..MAX_NODES
  always_comb begin
    if (nc_r == '0) begin
      node_lim = CW'(1);
    end else if (CW'(nc_r) > MAXN) begin
      node_lim = MAXN;
    end else begin
      node_lim = CW'(nc_r);
    end
  end

  assign out_busy = out_valid_r & out_stall;
  assign in_stall = ~(ctrl.take & ~flags.clr_busy);

  ufsf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  ufsf_dp #(
    .MAX_NODES       (MAX_NODES),
    .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_valid (in_valid),
    .in_data  (in_data),
    .node_lim (node_lim),
    .flags    (flags),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld && !out_busy) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ufsf_seq.sv */
// ----------------------------------------------------------------------------
// ufsf_seq
// Microcode sequencer: step counter, control store and branch unit. Each
// step issues one control word and picks the jump or the next address.
// ----------------------------------------------------------------------------
module ufsf_seq
  import ufsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        out_busy,
  input  ufsf_flags_t flags,
  output ufsf_ctrl_t  ctrl
);

  logic [STEP_W-1:0] upc_r;
  logic [STEP_W-1:0] upc_nxt;
  ufsf_ctrl_t        cw;
  logic              hit;

  // control store
  always_comb begin
    cw      = '0;
    cw.cond = C_ALWAYS;
    cw.jmp  = S_IDLE;
    cw.nxt  = S_IDLE;
    unique case (upc_r)
      S_IDLE: begin
        // wait for a request and latch it
        cw.cond = C_NO_REQ;
        cw.jmp  = S_IDLE;
        cw.nxt  = S_CHECK;
        cw.take = 1'b1;
      end
      S_CHECK: begin
        // bad labels go straight to the result
        cw.cond  = C_BAD;
        cw.jmp   = S_EMIT;
        cw.nxt   = S_WALK;
        cw.rd_op = RD_CUR;
      end
      S_WALK: begin
        // one parent hop per step until a node points at itself
        cw.cond    = C_RD_NE_CUR;
        cw.jmp     = S_WALK;
        cw.nxt     = S_REWIND;
        cw.cur_op  = CUR_FOLLOW;
        cw.rd_op   = RD_DATA;
        cw.root_ld = 1'b1;
      end
      S_REWIND: begin
        cw.cond   = C_NEVER;
        cw.nxt    = S_CTEST;
        cw.cur_op = CUR_START;
      end
      S_CTEST: begin
        cw.cond  = C_CUR_EQ_ROOT;
        cw.jmp   = S_PHASE;
        cw.nxt   = S_CPATH;
        cw.rd_op = RD_CUR;
      end
      S_CPATH: begin
        // re-point each node on the path at the root
        cw.cond    = C_RD_NE_ROOT;
        cw.jmp     = S_CPATH;
        cw.nxt     = S_PHASE;
        cw.wr_path = 1'b1;
        cw.cur_op  = CUR_FOLLOW;
        cw.rd_op   = RD_DATA;
      end
      S_PHASE: begin
        cw.cond = C_PHASE_B;
        cw.jmp  = S_LINK;
        cw.nxt  = S_LOAD_B;
      end
      S_LOAD_B: begin
        cw.cond   = C_NEVER;
        cw.nxt    = S_READ_B;
        cw.cur_op = CUR_SECOND;
      end
      S_READ_B: begin
        cw.cond  = C_ALWAYS;
        cw.jmp   = S_WALK;
        cw.rd_op = RD_CUR;
      end
      S_LINK: begin
        cw.cond = C_NEVER;
        cw.nxt  = S_EMIT;
        cw.link = 1'b1;
      end
      S_EMIT: begin
        // hold until the output register is free
        cw.cond   = C_OUT_BUSY;
        cw.jmp    = S_EMIT;
        cw.nxt    = S_IDLE;
        cw.out_ld = 1'b1;
      end
      default: begin
        cw.cond = C_ALWAYS;
        cw.jmp  = S_IDLE;
      end
    endcase
  end

  // branch condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:       hit = 1'b0;
      C_ALWAYS:      hit = 1'b1;
      C_NO_REQ:      hit = ~(in_valid & ~flags.clr_busy);
      C_BAD:         hit = flags.bad;
      C_RD_NE_CUR:   hit = flags.rd_ne_cur;
      C_CUR_EQ_ROOT: hit = flags.cur_eq_root;
      C_RD_NE_ROOT:  hit = flags.rd_ne_root;
      C_PHASE_B:     hit = flags.phase_b;
      C_OUT_BUSY:    hit = out_busy;
      default:       hit = 1'b1;
    endcase
  end

  assign upc_nxt = hit ? cw.jmp : cw.nxt;
  assign ctrl    = cw;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* rtl/ufsf_dp.sv */
// ----------------------------------------------------------------------------
// ufsf_dp
// Datapath: parent memory with its clearing sweep, walk and root registers,
// edge and union counters, and the result fields.
// ----------------------------------------------------------------------------
module ufsf_dp
  import ufsf_pkg::*;
#(
  parameter int  MAX_NODES       = 1024,
  parameter int  EDGE_COUNT_BITS = 16,
  localparam int NW              = $clog2(MAX_NODES),
  localparam int CW              = ((NW + 1) > 12) ? (NW + 1) : 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ufsf_ctrl_t      ctrl,
  input  logic            in_valid,
  input  ufsf_in_t        in_data,
  input  logic [CW-1:0]   node_lim,
  output ufsf_flags_t     flags,
  output ufsf_out_t       res
);

  // label to zero-based index
  function automatic logic [NW-1:0] to_idx(input logic [NODE_W-1:0] lbl);
    logic [CW-1:0] w;
    w = CW'(lbl) - CW'(1);
    return w[NW-1:0];
  endfunction

  logic [NW-1:0] mem [MAX_NODES];

  logic                       clr_busy_r;
  logic [NW-1:0]              clr_idx_r;
  logic [NW-1:0]              cur_r;
  logic [NW-1:0]              start_r;
  logic [NW-1:0]              root_r;
  logic [NW-1:0]              ra_r;
  logic [NW-1:0]              bidx_r;
  logic [NW-1:0]              rdata_r;
  logic                       phase_r;
  logic                       bad_r;
  logic                       last_r;
  logic                       joined_r;
  logic [EDGE_COUNT_BITS-1:0] edge_cnt_r;
  logic [NW-1:0]              uc_r;

  logic                       acc;
  logic                       bad_in;
  logic                       do_link;
  logic                       we;
  logic [NW-1:0]              wa;
  logic [NW-1:0]              wd;
  logic                       re;
  logic [NW-1:0]              rd_addr;
  logic [CW-1:0]              uc_ext;
  logic [CW-1:0]              comps;
  logic [EDGE_COUNT_BITS+15:0] edge_wide;

  // request taken in the idle step once the memory is cleared
  assign acc = ctrl.take & in_valid & ~clr_busy_r;

  // label range check
  assign bad_in = (in_data.first_node == '0) || (CW'(in_data.first_node) > node_lim) ||
                  (in_data.second_node == '0) || (CW'(in_data.second_node) > node_lim);

  assign do_link = ctrl.link & (ra_r != root_r);

  // clearing sweep after reset: entry i points to itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == NW'(MAX_NODES - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + NW'(1);
      end
    end
  end

  // memory port selection
  always_comb begin
    we      = clr_busy_r | ctrl.wr_path | do_link;
    wa      = clr_busy_r ? clr_idx_r : (ctrl.link ? ra_r : cur_r);
    wd      = clr_busy_r ? clr_idx_r : root_r;
    re      = (ctrl.rd_op != RD_NONE);
    rd_addr = (ctrl.rd_op == RD_DATA) ? rdata_r : cur_r;
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r <= '0;
      uc_r       <= '0;
    end else begin
      if (acc) begin
        edge_cnt_r <= edge_cnt_r + EDGE_COUNT_BITS'(1);
      end
      if (do_link) begin
        uc_r <= uc_r + NW'(1);
      end
    end
  end

  // walk registers and request fields
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_r    <= to_idx(in_data.first_node);
      start_r  <= to_idx(in_data.first_node);
      bidx_r   <= to_idx(in_data.second_node);
      last_r   <= in_data.last_edge;
      bad_r    <= bad_in;
      phase_r  <= 1'b0;
      joined_r <= 1'b0;
    end else begin
      case (ctrl.cur_op)
        CUR_START:  cur_r <= start_r;
        CUR_FOLLOW: cur_r <= rdata_r;
        CUR_SECOND: begin
          cur_r   <= bidx_r;
          start_r <= bidx_r;
          ra_r    <= root_r;
          phase_r <= 1'b1;
        end
        default: ;
      endcase
      if (ctrl.root_ld) begin
        root_r <= rdata_r;
      end
      if (do_link) begin
        joined_r <= 1'b1;
      end
    end
  end

  // status to the sequencer
  always_comb begin
    flags.clr_busy    = clr_busy_r;
    flags.bad         = bad_r;
    flags.rd_ne_cur   = (rdata_r != cur_r);
    flags.cur_eq_root = (cur_r == root_r);
    flags.rd_ne_root  = (rdata_r != root_r);
    flags.phase_b     = phase_r;
  end

  // result fields
  always_comb begin
    uc_ext    = CW'(uc_r);
    comps     = (uc_ext >= node_lim) ? CW'(1) : (node_lim - uc_ext);
    edge_wide = {16'd0, edge_cnt_r};
    res.joined      = joined_r;
    res.edge_number = edge_wide[15:0];
    res.components  = comps[NODE_W-1:0];
    res.connected   = (comps == CW'(1));
    res.final_res   = last_r;
    res.bad_node    = bad_r;
  end

endmodule
